FILE: rtl/core/mtsw_pkg.sv
// ----------------------------------------------------------------------------
// mtsw_pkg
// Shared types and constants of the multi-client software watchdog.
// ----------------------------------------------------------------------------
package mtsw_pkg;

  // Slot table geometry
  localparam int unsigned CLIENT_SLOTS = 8;
  localparam int unsigned SLOT_W       = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int unsigned SLOT_FIELD_W = 3;
  localparam int unsigned SLOT_EXT_W   = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TID_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TMO_W    = 4;
  localparam int unsigned SEC_W    = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [TMO_W-1:0] TMO_RESET    = TMO_W'(6);
  localparam logic [SEC_W-1:0] PERIOD_RESET = SEC_W'(10);
  localparam logic [SEC_W-1:0] SEC_MAX      = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_SIGN       = 2'd1,
    CMD_UNREGISTER = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_ALREADY = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NOT_REG = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_PERIOD  = 1'b1
  } cfg_idx_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // execute the captured transaction and register the result
  } ctrl_t;

endpackage

FILE: rtl/core/multi_task_software_watchdog_top.sv
// ----------------------------------------------------------------------------
// multi_task_software_watchdog_top
// Multi-client software watchdog: register, sign, unregister and tick commands
// against a table of client slots, with a sticky reboot request.
// ----------------------------------------------------------------------------
// Flow: a command accepted on start is captured, executed in the execute
//   state, and its result is registered onto the result ports, marked by done_o.
// Busy: no new command is taken while busy; all slots are scanned in
//   parallel in the execute state; the receiver cannot stall results.
// Reset: rst_ni clears the slot used flags, tick counter and trip flag, but
//   not the result registers, and sets the configuration to its defaults.
module multi_task_software_watchdog_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [mtsw_pkg::CMD_W-1:0]          command_i,
  input  logic [mtsw_pkg::TID_W-1:0]          task_id_i,
  input  logic [mtsw_pkg::SLOT_FIELD_W-1:0]   slot_i,
  input  logic                                cfg_we_i,
  input  logic [mtsw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mtsw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                done_o,
  output logic [mtsw_pkg::STATUS_W-1:0]       status_o,
  output logic [mtsw_pkg::SLOT_FIELD_W-1:0]   slot_out_o,
  output logic                                feed_hw_o,
  output logic                                reboot_request_o,
  output logic [mtsw_pkg::SLOT_FIELD_W-1:0]   expired_slot_o,
  output logic                                expired_valid_o
);
  import mtsw_pkg::*;

  ctrl_t ctrl;

  // Sequence each transaction
  mtsw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .ctrl_o (ctrl)
  );

  // Execute commands on the slot table
  mtsw_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .command_i        (command_i),
    .task_id_i        (task_id_i),
    .slot_i           (slot_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .status_o         (status_o),
    .slot_out_o       (slot_out_o),
    .feed_hw_o        (feed_hw_o),
    .reboot_request_o (reboot_request_o),
    .expired_slot_o   (expired_slot_o),
    .expired_valid_o  (expired_valid_o)
  );

endmodule

FILE: rtl/core/mtsw_ctrl.sv
// ----------------------------------------------------------------------------
// mtsw_ctrl
// Sequencer: accepts one command transaction, runs it through the datapath
// and strobes the result.
// ----------------------------------------------------------------------------
module mtsw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output logic            done_o,
  output mtsw_pkg::ctrl_t ctrl_o
);
  import mtsw_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Issue commands to the datapath
  assign ctrl_o.load = start && (state_q == S_IDLE);
  assign ctrl_o.exec = (state_q == S_EXEC);

  // Advance the state machine
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

FILE: rtl/core/mtsw_dp.sv
// ----------------------------------------------------------------------------
// mtsw_dp
// Datapath: configuration registers, slot table, tick counter, sticky
// reboot request and the result registers.
// ----------------------------------------------------------------------------
module mtsw_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mtsw_pkg::ctrl_t                     ctrl_i,
  input  logic [mtsw_pkg::CMD_W-1:0]          command_i,
  input  logic [mtsw_pkg::TID_W-1:0]          task_id_i,
  input  logic [mtsw_pkg::SLOT_FIELD_W-1:0]   slot_i,
  input  logic                                cfg_we_i,
  input  logic [mtsw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mtsw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [mtsw_pkg::STATUS_W-1:0]       status_o,
  output logic [mtsw_pkg::SLOT_FIELD_W-1:0]   slot_out_o,
  output logic                                feed_hw_o,
  output logic                                reboot_request_o,
  output logic [mtsw_pkg::SLOT_FIELD_W-1:0]   expired_slot_o,
  output logic                                expired_valid_o
);
  import mtsw_pkg::*;

  // Configuration
  logic [TMO_W-1:0] tmo_q;
  logic [SEC_W-1:0] period_q;

  // Captured transaction
  logic [CMD_W-1:0]        cmd_q;
  logic [TID_W-1:0]        tid_q;
  logic [SLOT_FIELD_W-1:0] slot_q;

  // Slot table
  logic [TID_W-1:0]        slot_task_q [CLIENT_SLOTS];
  logic [TMO_W-1:0]        rem_q       [CLIENT_SLOTS];
  logic [TMO_W-1:0]        rem_d       [CLIENT_SLOTS];
  logic [CLIENT_SLOTS-1:0] used_q, used_d;
  logic [SEC_W-1:0]        sec_q, sec_d;
  logic                    tripped_q, tripped_d;

  // Result registers
  logic [STATUS_W-1:0]     status_q, status_d;
  logic [SLOT_FIELD_W-1:0] slot_out_q, slot_out_d;
  logic                    feed_q, feed_d;
  logic                    reboot_q;
  logic [SLOT_FIELD_W-1:0] exp_slot_q, exp_slot_d;
  logic                    exp_valid_q, exp_valid_d;

  // Decode helpers
  logic [SLOT_EXT_W-1:0]   slot_ext;
  logic [SLOT_W-1:0]       sidx;
  logic                    slot_ok;
  logic                    dup;
  logic                    free_found;
  logic [SLOT_W-1:0]       free_idx;
  logic [SLOT_EXT_W-1:0]   free_ext;
  logic                    write_task;
  logic [SEC_W-1:0]        sec_inc;
  logic                    check;
  logic [SLOT_W-1:0]       exp_idx;
  logic [SLOT_EXT_W-1:0]   exp_ext;

  // Capture the incoming transaction
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= command_i;
      tid_q  <= task_id_i;
      slot_q <= slot_i;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q    <= TMO_RESET;
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT: tmo_q    <= cfg_data_i[TMO_W-1:0];
        CFG_PERIOD:  period_q <= cfg_data_i[SEC_W-1:0];
        default:     tmo_q    <= tmo_q;
      endcase
    end
  end

  // Resolve the addressed slot
  assign slot_ext = SLOT_EXT_W'(slot_q);
  assign sidx     = slot_ext[SLOT_W-1:0];
  assign slot_ok  = (32'(slot_q) < CLIENT_SLOTS) && used_q[sidx];

  // Scan for a duplicate id and the lowest free slot
  always_comb begin
    dup        = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
      if (used_q[i]) begin
        if (slot_task_q[i] == tid_q) begin
          dup = 1'b1;
        end
      end else begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end
  assign free_ext = SLOT_EXT_W'(free_idx);

  // Advance the one-second counter
  assign sec_inc = (sec_q == SEC_MAX) ? sec_q : sec_q + SEC_W'(1);
  assign check   = (sec_inc >= period_q);

  // Count every live slot down and find the lowest one that expires
  always_comb begin
    exp_valid_d = 1'b0;
    exp_idx     = '0;
    for (int i = 0; i < CLIENT_SLOTS; i++) begin
      rem_d[i] = rem_q[i];
    end
    for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
      if (used_q[i] && (rem_q[i] != '0)) begin
        rem_d[i] = rem_q[i] - TMO_W'(1);
        if (rem_q[i] == TMO_W'(1)) begin
          exp_valid_d = 1'b1;
          exp_idx     = SLOT_W'(i);
        end
      end
    end
  end
  assign exp_ext = SLOT_EXT_W'(exp_idx);

  // Execute the captured command
  always_comb begin
    used_d     = used_q;
    sec_d      = sec_q;
    tripped_d  = tripped_q;
    status_d   = STAT_OK;
    slot_out_d = '0;
    feed_d     = 1'b0;
    exp_slot_d = '0;
    write_task = 1'b0;
    unique case (cmd_e'(cmd_q))
      CMD_REGISTER: begin
        if (dup) begin
          status_d = STAT_ALREADY;
        end else if (!free_found) begin
          status_d = STAT_FULL;
        end else begin
          used_d[free_idx] = 1'b1;
          write_task       = 1'b1;
          slot_out_d       = free_ext[SLOT_FIELD_W-1:0];
        end
      end
      CMD_SIGN: begin
        if (!slot_ok) begin
          status_d = STAT_NOT_REG;
        end
      end
      CMD_UNREGISTER: begin
        if (!slot_ok) begin
          status_d = STAT_NOT_REG;
        end else begin
          used_d[sidx] = 1'b0;
        end
      end
      CMD_TICK: begin
        feed_d = 1'b1;
        if (check) begin
          sec_d = '0;
          if (exp_valid_d) begin
            tripped_d  = 1'b1;
            exp_slot_d = exp_ext[SLOT_FIELD_W-1:0];
          end
        end else begin
          sec_d = sec_inc;
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
  end

  // Hold control state of the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      sec_q     <= '0;
      tripped_q <= 1'b0;
    end else if (ctrl_i.exec) begin
      used_q    <= used_d;
      sec_q     <= sec_d;
      tripped_q <= tripped_d;
    end
  end

  // Update slot payload: task id, reload on register or sign, count down on check
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      unique case (cmd_e'(cmd_q))
        CMD_REGISTER: begin
          if (write_task) begin
            slot_task_q[free_idx] <= tid_q;
            rem_q[free_idx]       <= tmo_q;
          end
        end
        CMD_SIGN: begin
          if (slot_ok && (rem_q[sidx] != '0)) begin
            rem_q[sidx] <= tmo_q;
          end
        end
        CMD_TICK: begin
          if (check) begin
            for (int i = 0; i < CLIENT_SLOTS; i++) begin
              rem_q[i] <= rem_d[i];
            end
          end
        end
        default: begin
          rem_q[0] <= rem_q[0];
        end
      endcase
    end
  end

  // Register the result transaction
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      status_q    <= status_d;
      slot_out_q  <= slot_out_d;
      feed_q      <= feed_d;
      reboot_q    <= tripped_d;
      exp_slot_q  <= exp_slot_d;
      exp_valid_q <= exp_valid_d && check && (cmd_e'(cmd_q) == CMD_TICK);
    end
  end

  assign status_o         = status_q;
  assign slot_out_o       = slot_out_q;
  assign feed_hw_o        = feed_q;
  assign reboot_request_o = reboot_q;
  assign expired_slot_o   = exp_slot_q;
  assign expired_valid_o  = exp_valid_q;

endmodule

FILE: rtl/core/mtsw_checker.sv
// ----------------------------------------------------------------------------
// mtsw_checker
// Port-level checks of the watchdog command sequence and result strobe.
// ----------------------------------------------------------------------------
module mtsw_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                done_o,
  input logic [mtsw_pkg::STATUS_W-1:0]       status_o,
  input logic                                feed_hw_o,
  input logic                                reboot_request_o,
  input logic                                expired_valid_o
);
  import mtsw_pkg::*;

  // Every accepted transaction yields a result strobe
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted transaction produced no result strobe");

  // A result strobe leaves the block ready for the next transaction
  a_idle_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("block still busy while strobing a result");

  // A tick result is always ok and feeds the hardware dog
  a_tick_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && feed_hw_o) |-> (status_o == STAT_OK))
    else $error("tick result carries an error status");

  // An expiry report always comes with the reboot request raised
  a_expiry_trips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && expired_valid_o) |-> (reboot_request_o && feed_hw_o))
    else $error("expiry reported without reboot request");

  // The reboot request never falls once raised
  a_reboot_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && reboot_request_o) |=> reboot_request_o)
    else $error("reboot request dropped");

endmodule

bind multi_task_software_watchdog_top mtsw_checker u_mtsw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .status_o         (status_o),
  .feed_hw_o        (feed_hw_o),
  .reboot_request_o (reboot_request_o),
  .expired_valid_o  (expired_valid_o)
);
